// ----- sv/hsv_color_pixel_classifier_defines.svh -----
// assertion macros used by the checker file
`ifndef HSV_COLOR_PIXEL_CLASSIFIER_DEFINES_SVH
`define HSV_COLOR_PIXEL_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HSVCLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HSVCLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hsvcls_pkg.sv -----
package hsvcls_pkg;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] REG_HUE_LOW  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HUE_HIGH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SAT_LOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SAT_HIGH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VAL_LOW  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_VAL_HIGH = 3'd5;

  // arithmetic constants
  localparam int unsigned HUE_SECTOR = 120;
  localparam int unsigned HUE_FULL   = 360;
  localparam int unsigned HUE_SCALE  = 60;
  localparam int unsigned PCT_SCALE  = 100;
  // value = (100 * max) / 255 as (max * 100 * 257 + 257) >> 16
  localparam int unsigned VAL_RECIP  = 25700;
  localparam int unsigned VAL_ROUND  = 257;
  localparam int unsigned VAL_SHIFT  = 16;
  localparam int unsigned VAL_PROD_W = 23;

  // restoring divider sizes
  localparam int unsigned DIV_Q_W = 7;
  localparam int unsigned DIV_R_W = 15;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic       member;
    logic       achromatic;
    logic [8:0] hue_deg;
    logic [6:0] saturation_pct;
    logic [6:0] value_pct;
  } out_item_t;

  typedef struct packed {
    logic [8:0] hue_low;
    logic [9:0] hue_high;
    logic [6:0] sat_low;
    logic [6:0] sat_high;
    logic [6:0] val_low;
    logic [6:0] val_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hue_low:  9'd0,
    hue_high: 10'd360,
    sat_low:  7'd0,
    sat_high: 7'd101,
    val_low:  7'd0,
    val_high: 7'd101
  };

  // after max/min selection
  typedef struct packed {
    chan_t      imax;
    logic [7:0] cmax;
    logic [7:0] chroma;
    logic       diff_neg;
    logic [7:0] diff_mag;
  } sel_t;

  // carried through the divider stages
  typedef struct packed {
    chan_t              imax;
    logic               hue_neg;
    logic               achromatic;
    logic [6:0]         val;
    logic [7:0]         hue_den;
    logic [7:0]         sat_den;
    logic [DIV_R_W-1:0] hue_rem;
    logic [DIV_R_W-1:0] sat_rem;
    logic [DIV_Q_W-1:0] hue_q;
    logic [DIV_Q_W-1:0] sat_q;
  } div_item_t;

endpackage

// ----- sv/hsv_color_pixel_classifier.sv -----
// RGB pixel to integer HSV classifier. Each item is one 8-bit RGB pixel and gives exactly
// one result: hue in degrees (0..359), saturation and value in percent (0..100), an
// achromatic flag and a member flag that is set when H, S and V each lie strictly inside
// the programmed bounds (hue_high above 360 wraps the hue window). Throughput is one item
// per clock while out_ready does not stall. From input accept to output valid an item
// passes the max/min selection and dividend forming stages, a pipelined restoring divider
// that produces one quotient bit per stage for hue and saturation side by side, and a
// final stage of hue assembly, bound compare and output register. Each stage holds its own
// valid bit, so a stall on out_ready backs up stage by stage and bubbles are squeezed out.
// Write the bound registers only while the pipeline is empty.
module hsv_color_pixel_classifier import hsvcls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  // classification result
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  // bound registers
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;

  // front end to divider
  logic      fd_valid;
  logic      fd_ready;
  div_item_t fd_item;

  // divider to back end
  logic      db_valid;
  logic      db_ready;
  div_item_t db_item;

  // register writes, out-of-range indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_HUE_LOW:  cfg_nxt.hue_low  = cfg_wdata[8:0];
        REG_HUE_HIGH: cfg_nxt.hue_high = cfg_wdata[9:0];
        REG_SAT_LOW:  cfg_nxt.sat_low  = cfg_wdata[6:0];
        REG_SAT_HIGH: cfg_nxt.sat_high = cfg_wdata[6:0];
        REG_VAL_LOW:  cfg_nxt.val_low  = cfg_wdata[6:0];
        REG_VAL_HIGH: cfg_nxt.val_high = cfg_wdata[6:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // max / min, chroma, hue and saturation dividends, value percent
  hsvcls_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (fd_valid),
    .out_ready (fd_ready),
    .out_item  (fd_item)
  );

  // both truncating divisions, one quotient bit per stage
  hsvcls_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fd_valid),
    .in_ready  (fd_ready),
    .in_item   (fd_item),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_item  (db_item)
  );

  // hue sector offset, wrap, bound checks and output register
  hsvcls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (db_valid),
    .in_ready  (db_ready),
    .in_item   (db_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- sv/hsvcls_front.sv -----
module hsvcls_front import hsvcls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  chan_t             imax;
  logic [7:0]        mx;
  logic [7:0]        mn;
  logic signed [8:0] diff;
  sel_t              sel_nxt;
  sel_t              sel_r;
  logic              sel_valid_r;
  logic              sel_ready;

  div_item_t         div_nxt;
  div_item_t         div_r;
  logic              div_valid_r;
  logic              div_ready;
  logic [VAL_PROD_W-1:0] val_prod;

  // stage 1: max / min, earlier channel wins ties
  always_comb begin
    imax = CH_RED;
    mx   = in_item.red;
    mn   = in_item.red;
    if (in_item.green > mx) begin
      imax = CH_GREEN;
      mx   = in_item.green;
    end
    if (in_item.blue > mx) begin
      imax = CH_BLUE;
      mx   = in_item.blue;
    end
    if (in_item.green < mn) begin
      mn = in_item.green;
    end
    if (in_item.blue < mn) begin
      mn = in_item.blue;
    end
    case (imax)
      CH_RED:   diff = $signed({1'b0, in_item.green}) - $signed({1'b0, in_item.blue});
      CH_GREEN: diff = $signed({1'b0, in_item.blue}) - $signed({1'b0, in_item.red});
      CH_BLUE:  diff = $signed({1'b0, in_item.red}) - $signed({1'b0, in_item.green});
      default:  diff = '0;
    endcase
    sel_nxt.imax     = imax;
    sel_nxt.cmax     = mx;
    sel_nxt.chroma   = mx - mn;
    sel_nxt.diff_neg = diff[8];
    sel_nxt.diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
  end

  assign sel_ready = ~sel_valid_r | div_ready;
  assign in_ready  = sel_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
    end else if (sel_ready) begin
      sel_valid_r <= in_valid;
    end
    if (sel_ready && in_valid) begin
      sel_r <= sel_nxt;
    end
  end

  // stage 2: dividends and value percent
  always_comb begin
    val_prod = VAL_PROD_W'(sel_r.cmax) * VAL_PROD_W'(VAL_RECIP) + VAL_PROD_W'(VAL_ROUND);
    div_nxt.imax       = sel_r.imax;
    div_nxt.hue_neg    = sel_r.diff_neg;
    div_nxt.achromatic = (sel_r.chroma == 8'd0);
    div_nxt.val        = val_prod[VAL_SHIFT +: 7];
    div_nxt.hue_den    = sel_r.chroma;
    div_nxt.sat_den    = sel_r.cmax;
    div_nxt.hue_rem    = DIV_R_W'(sel_r.diff_mag) * DIV_R_W'(HUE_SCALE);
    div_nxt.sat_rem    = DIV_R_W'(sel_r.chroma) * DIV_R_W'(PCT_SCALE);
    div_nxt.hue_q      = '0;
    div_nxt.sat_q      = '0;
  end

  assign div_ready = ~div_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r <= 1'b0;
    end else if (div_ready) begin
      div_valid_r <= sel_valid_r;
    end
    if (div_ready && sel_valid_r) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = div_valid_r;
  assign out_item  = div_r;

endmodule

// ----- sv/hsvcls_divider.sv -----
module hsvcls_divider import hsvcls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  // one restoring step: try the divisor shifted to quotient bit sh
  function automatic div_item_t div_step(div_item_t d, int unsigned sh);
    div_item_t          r;
    logic [DIV_R_W-1:0] hd;
    logic [DIV_R_W-1:0] sd;
    r  = d;
    hd = DIV_R_W'(d.hue_den) << sh;
    sd = DIV_R_W'(d.sat_den) << sh;
    if (d.hue_rem >= hd) begin
      r.hue_rem = d.hue_rem - hd;
      r.hue_q   = {d.hue_q[DIV_Q_W-2:0], 1'b1};
    end else begin
      r.hue_q   = {d.hue_q[DIV_Q_W-2:0], 1'b0};
    end
    if (d.sat_rem >= sd) begin
      r.sat_rem = d.sat_rem - sd;
      r.sat_q   = {d.sat_q[DIV_Q_W-2:0], 1'b1};
    end else begin
      r.sat_q   = {d.sat_q[DIV_Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  div_item_t          src  [DIV_Q_W+1];
  logic [DIV_Q_W:0]   vsrc;
  logic [DIV_Q_W:0]   rdy;
  div_item_t          stg_r   [DIV_Q_W];
  div_item_t          stg_nxt [DIV_Q_W];
  logic [DIV_Q_W-1:0] vld_r;

  assign src[0]       = in_item;
  assign vsrc[0]      = in_valid;
  assign rdy[DIV_Q_W] = out_ready;
  assign in_ready     = rdy[0];

  for (genvar s = 0; s < DIV_Q_W; s++) begin : g_stage
    // msb of the quotient first
    assign stg_nxt[s] = div_step(src[s], DIV_Q_W - 1 - s);
    assign rdy[s]     = ~vld_r[s] | rdy[s+1];
    assign src[s+1]   = stg_r[s];
    assign vsrc[s+1]  = vld_r[s];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= vsrc[s];
      end
      if (rdy[s] && vsrc[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign out_valid = vsrc[DIV_Q_W];
  assign out_item  = src[DIV_Q_W];

endmodule

// ----- sv/hsvcls_back.sv -----
module hsvcls_back import hsvcls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic signed [10:0] base;
  logic signed [10:0] quo;
  logic signed [10:0] hue_s;
  logic [8:0]         hue;
  logic [9:0]         hue_wrap;
  logic               hue_ok;
  logic [6:0]         sat;
  logic               member;
  out_item_t          res_nxt;
  out_item_t          res_r;
  logic               res_valid_r;

  always_comb begin
    case (in_item.imax)
      CH_RED:   base = 11'sd0;
      CH_GREEN: base = 11'(HUE_SECTOR);
      CH_BLUE:  base = 11'(2 * HUE_SECTOR);
      default:  base = 11'sd0;
    endcase
    quo   = $signed(11'(in_item.hue_q));
    hue_s = in_item.hue_neg ? base - quo : base + quo;
    if (hue_s[10]) begin
      hue_s = hue_s + 11'(HUE_FULL);
    end
    hue = hue_s[8:0];
    sat = in_item.sat_q;

    // hue_high above a full turn wraps around
    hue_wrap = cfg.hue_high - 10'(HUE_FULL);
    if (cfg.hue_high > 10'(HUE_FULL)) begin
      hue_ok = (hue > cfg.hue_low) || ({1'b0, hue} < hue_wrap);
    end else begin
      hue_ok = (hue > cfg.hue_low) && ({1'b0, hue} < cfg.hue_high);
    end

    member = !in_item.achromatic && hue_ok
           && (sat > cfg.sat_low) && (sat < cfg.sat_high)
           && (in_item.val > cfg.val_low) && (in_item.val < cfg.val_high);

    res_nxt.member     = member;
    res_nxt.achromatic = in_item.achromatic;
    if (in_item.achromatic) begin
      res_nxt.hue_deg        = '0;
      res_nxt.saturation_pct = '0;
      res_nxt.value_pct      = '0;
    end else begin
      res_nxt.hue_deg        = hue;
      res_nxt.saturation_pct = sat;
      res_nxt.value_pct      = in_item.val;
    end
  end

  assign in_ready = ~res_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_ready) begin
      res_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_item  = res_r;

endmodule

// ----- sv/hsvcls_checker.sv -----
`include "hsv_color_pixel_classifier_defines.svh"

module hsvcls_checker import hsvcls_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // achromatic results carry zero fields and are never members
  `HSVCLS_ASSERT_NOW(a_achrom_zero, out_valid && out_item.achromatic, !out_item.member && out_item.hue_deg == 9'd0 && out_item.saturation_pct == 7'd0 && out_item.value_pct == 7'd0, "achromatic item with nonzero fields")

  // hsv fields stay in range
  `HSVCLS_ASSERT_NOW(a_field_range, out_valid, out_item.hue_deg < 9'd360 && out_item.saturation_pct <= 7'd100 && out_item.value_pct <= 7'd100, "hsv field out of range")

  // a member has strictly positive saturation and value
  `HSVCLS_ASSERT_NOW(a_member_nonzero, out_valid && out_item.member, !out_item.achromatic && out_item.saturation_pct != 7'd0 && out_item.value_pct != 7'd0, "member with zero saturation or value")

  // a stalled result holds
  `HSVCLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind hsv_color_pixel_classifier hsvcls_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
